>>> sv/kclp_pkg.sv
// kclp_pkg: shared types and constants for the key click / long press detector
// depends on nothing; imported by kclp_lane, kclp_merge and the top level
package kclp_pkg;

	// key layout: bitmap keys first, then the two mouse buttons
	localparam int KBD_KEYS   = 16;
	localparam int BITMAP_W   = 16;
	localparam int KEY_COUNT  = 18;
	localparam int MOUSE_L    = 16;
	localparam int MOUSE_R    = 17;
	localparam int TIME_W     = 16;
	localparam int BIT_IDX_W  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int MODE_W     = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CLICK_MIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CTRL_BIT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_BIT  = 2'd3;

	// configuration reset values
	localparam logic [TIME_W-1:0]    CLICK_MIN_RST  = 16'd50;
	localparam logic [TIME_W-1:0]    LONG_PRESS_RST = 16'd200;
	localparam logic [BIT_IDX_W-1:0] CTRL_BIT_RST   = 4'd5;
	localparam logic [BIT_IDX_W-1:0] SHIFT_BIT_RST  = 4'd4;

	// modifier mode codes
	localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CTRL  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SHIFT = 2'd2;

	// per-key events found by one lane for one tick
	typedef struct packed {
		logic down;
		logic up;
		logic held;
		logic click;
		logic lng;
	} lane_ev_t;

endpackage

>>> sv/key_click_long_press_detector_top.sv
// key_click_long_press_detector_top: 18 key lanes, merge and output register
// depends on kclp_pkg, kclp_lane and kclp_merge
//
//  channel  handshake                  payload
//  in       in_valid / in_ready        keyboard_keys, mouse_left, mouse_right, now_ms
//  out      out_valid / out_ready      down_mask, up_mask, held_mask, click_mask,
//                                      long_mask, modifier_mode
//  cfg      cfg_we (no wait)           cfg_index, cfg_data
//
// one tick per cycle while the output is being taken; a result appears in the cycle after its input transfer
// latency is set by the single output register behind the 18 parallel lanes
// in_ready is high whenever the output register is empty or being taken
// reset clears key levels, press times and the last tick time, and loads the
// default config
module key_click_long_press_detector_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [kclp_pkg::BITMAP_W-1:0]       keyboard_keys,
	input  logic                                mouse_left,
	input  logic                                mouse_right,
	input  logic [kclp_pkg::TIME_W-1:0]         now_ms,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [kclp_pkg::KEY_COUNT-1:0]      down_mask,
	output logic [kclp_pkg::KEY_COUNT-1:0]      up_mask,
	output logic [kclp_pkg::KEY_COUNT-1:0]      held_mask,
	output logic [kclp_pkg::KEY_COUNT-1:0]      click_mask,
	output logic [kclp_pkg::KEY_COUNT-1:0]      long_mask,
	output logic [kclp_pkg::MODE_W-1:0]         modifier_mode,
	input  logic                                cfg_we,
	input  logic [kclp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kclp_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import kclp_pkg::*;

	logic [TIME_W-1:0]    click_min_q;
	logic [TIME_W-1:0]    long_press_q;
	logic [BIT_IDX_W-1:0] ctrl_bit_q;
	logic [BIT_IDX_W-1:0] shift_bit_q;
	logic [TIME_W-1:0]    prev_tick_q;
	logic                 tick;
	logic [KEY_COUNT-1:0] level;
	lane_ev_t             lane_ev [KEY_COUNT];

	assign tick = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			click_min_q  <= CLICK_MIN_RST;
			long_press_q <= LONG_PRESS_RST;
			ctrl_bit_q   <= CTRL_BIT_RST;
			shift_bit_q  <= SHIFT_BIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLICK_MIN:  click_min_q  <= cfg_data[TIME_W-1:0];
				REG_LONG_PRESS: long_press_q <= cfg_data[TIME_W-1:0];
				REG_CTRL_BIT:   ctrl_bit_q   <= cfg_data[BIT_IDX_W-1:0];
				REG_SHIFT_BIT:  shift_bit_q  <= cfg_data[BIT_IDX_W-1:0];
				default: ;
			endcase
		end
	end

	// time of the last tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_tick_q <= '0;
		end else if (tick) begin
			prev_tick_q <= now_ms;
		end
	end

	// key levels: bitmap keys that exist, then the mouse buttons
	always_comb begin
		for (int k = 0; k < BITMAP_W; k++) begin
			level[k] = (k < KBD_KEYS) ? keyboard_keys[k] : 1'b0;
		end
		level[MOUSE_L] = mouse_left;
		level[MOUSE_R] = mouse_right;
	end

	// one lane per key
	for (genvar g = 0; g < KEY_COUNT; g++) begin : g_lane
		kclp_lane u_lane (
			.clk             (clk),
			.arst_n          (arst_n),
			.tick            (tick),
			.level           (level[g]),
			.now_ms          (now_ms),
			.prev_tick_time  (prev_tick_q),
			.click_min_time  (click_min_q),
			.long_press_time (long_press_q),
			.ev              (lane_ev[g])
		);
	end

	// merge and output register
	kclp_merge u_merge (
		.clk             (clk),
		.arst_n          (arst_n),
		.tick            (tick),
		.lane_ev         (lane_ev),
		.keyboard_keys   (keyboard_keys),
		.ctrl_bit_index  (ctrl_bit_q),
		.shift_bit_index (shift_bit_q),
		.out_ready       (out_ready),
		.in_ready        (in_ready),
		.out_valid       (out_valid),
		.down_mask       (down_mask),
		.up_mask         (up_mask),
		.held_mask       (held_mask),
		.click_mask      (click_mask),
		.long_mask       (long_mask),
		.modifier_mode   (modifier_mode)
	);

	// a key has at most one of down, up and held per tick
	a_events_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((down_mask & up_mask) == '0 && (down_mask & held_mask) == '0
			&& (up_mask & held_mask) == '0))
		else $error("key reported with more than one transition");

	// a click is always a release
	a_click_is_up: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (click_mask & ~up_mask) == '0)
		else $error("click without release");

	// a long press is always a held key
	a_long_is_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (long_mask & ~held_mask) == '0)
		else $error("long press on key that is not held");

	// an accepted tick always shows up at the output on the next cycle
	a_tick_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> out_valid)
		else $error("accepted tick produced no result");

endmodule

>>> sv/kclp_lane.sv
// kclp_lane: tracker for one key: last level, press start time and tick events
// depends on kclp_pkg
module kclp_lane (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            tick,
	input  logic                            level,
	input  logic [kclp_pkg::TIME_W-1:0]     now_ms,
	input  logic [kclp_pkg::TIME_W-1:0]     prev_tick_time,
	input  logic [kclp_pkg::TIME_W-1:0]     click_min_time,
	input  logic [kclp_pkg::TIME_W-1:0]     long_press_time,
	output kclp_pkg::lane_ev_t              ev
);
	import kclp_pkg::*;

	logic              level_q;
	logic [TIME_W-1:0] press_start_q;
	logic [TIME_W-1:0] last_t;
	logic [TIME_W-1:0] cur_t;

	// held times, wrapping at 16 bits
	assign last_t = prev_tick_time - press_start_q;
	assign cur_t  = now_ms - press_start_q;

	// classify the tick for this key
	always_comb begin
		ev.down  = !level_q && level;
		ev.up    = level_q && !level;
		ev.held  = level_q && level;
		ev.click = ev.up && (cur_t > click_min_time) && (cur_t < long_press_time);
		ev.lng   = ev.held && (last_t <= long_press_time) && (cur_t > long_press_time);
	end

	// level updates on each input transfer; press start is taken when a press begins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q       <= 1'b0;
			press_start_q <= '0;
		end else if (tick) begin
			level_q <= level;
			if (!level_q && level) begin
				press_start_q <= now_ms;
			end
		end
	end

endmodule

>>> sv/kclp_merge.sv
// kclp_merge: gathers lane events into masks, finds the modifier mode and
// holds the result in the output register; depends on kclp_pkg
module kclp_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tick,
	input  kclp_pkg::lane_ev_t                lane_ev [kclp_pkg::KEY_COUNT],
	input  logic [kclp_pkg::BITMAP_W-1:0]     keyboard_keys,
	input  logic [kclp_pkg::BIT_IDX_W-1:0]    ctrl_bit_index,
	input  logic [kclp_pkg::BIT_IDX_W-1:0]    shift_bit_index,
	input  logic                              out_ready,
	output logic                              in_ready,
	output logic                              out_valid,
	output logic [kclp_pkg::KEY_COUNT-1:0]    down_mask,
	output logic [kclp_pkg::KEY_COUNT-1:0]    up_mask,
	output logic [kclp_pkg::KEY_COUNT-1:0]    held_mask,
	output logic [kclp_pkg::KEY_COUNT-1:0]    click_mask,
	output logic [kclp_pkg::KEY_COUNT-1:0]    long_mask,
	output logic [kclp_pkg::MODE_W-1:0]       modifier_mode
);
	import kclp_pkg::*;

	logic [KEY_COUNT-1:0] down_d, up_d, held_d, click_d, long_d;
	logic [MODE_W-1:0]    mode_d;
	logic                 out_valid_q;

	// pack lane events into masks
	always_comb begin
		for (int k = 0; k < KEY_COUNT; k++) begin
			down_d[k]  = lane_ev[k].down;
			up_d[k]    = lane_ev[k].up;
			held_d[k]  = lane_ev[k].held;
			click_d[k] = lane_ev[k].click;
			long_d[k]  = lane_ev[k].lng;
		end
	end

	// modifier mode, ctrl before shift
	always_comb begin
		if (keyboard_keys[ctrl_bit_index]) begin
			mode_d = MODE_CTRL;
		end else if (keyboard_keys[shift_bit_index]) begin
			mode_d = MODE_SHIFT;
		end else begin
			mode_d = MODE_NONE;
		end
	end

	// a new tick may enter whenever the output register frees this cycle
	assign in_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= tick;
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (tick) begin
			down_mask     <= down_d;
			up_mask       <= up_d;
			held_mask     <= held_d;
			click_mask    <= click_d;
			long_mask     <= long_d;
			modifier_mode <= mode_d;
		end
	end

endmodule
